// ----- design/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, codes and lookup functions of the start codon translator.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned ClassW  = 3;
  localparam int unsigned BaseW   = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRequireStart = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameOffset  = 1'd1;

  // nucleotide codes
  localparam logic [BaseW-1:0] BaseNone = 3'd0;
  localparam logic [BaseW-1:0] BaseA    = 3'd1;
  localparam logic [BaseW-1:0] BaseC    = 3'd2;
  localparam logic [BaseW-1:0] BaseG    = 3'd3;
  localparam logic [BaseW-1:0] BaseT    = 3'd4;
  localparam logic [BaseW-1:0] BaseU    = 3'd5;

  // charge classes
  localparam logic [ClassW-1:0] ClsPositive    = 3'd0;
  localparam logic [ClassW-1:0] ClsNegative    = 3'd1;
  localparam logic [ClassW-1:0] ClsHydrophobic = 3'd2;
  localparam logic [ClassW-1:0] ClsHydrophilic = 3'd3;
  localparam logic [ClassW-1:0] ClsUnknown     = 3'd4;

  localparam logic [CharW-1:0] ResStop  = "X";
  localparam logic [CharW-1:0] ResStart = "M";
  localparam logic [CharW-1:0] ResNone  = 8'd0;

  typedef struct packed {
    logic [CharW-1:0]  residue;
    logic [ClassW-1:0] charge_class;
    logic              has_residue;
    logic              protein_end;
  } res_t;

  function automatic logic [BaseW-1:0] encode_base(input logic [CharW-1:0] c);
    logic [CharW-1:0] u;
    logic [BaseW-1:0] b;
    u = c;
    if (c >= "a" && c <= "z") begin
      u = c - 8'd32;
    end
    case (u)
      "A":     b = BaseA;
      "C":     b = BaseC;
      "G":     b = BaseG;
      "T":     b = BaseT;
      "U":     b = BaseU;
      default: b = BaseNone;
    endcase
    return b;
  endfunction

  function automatic logic is_purine(input logic [BaseW-1:0] b);
    return (b == BaseA) || (b == BaseG);
  endfunction

  function automatic logic [CharW-1:0] codon_letter(input logic [BaseW-1:0] xi,
                                                    input logic [BaseW-1:0] yi,
                                                    input logic [BaseW-1:0] zi);
    logic [BaseW-1:0] x, y, z;
    logic [CharW-1:0] r;
    x = (xi == BaseU) ? BaseT : xi;
    y = (yi == BaseU) ? BaseT : yi;
    z = (zi == BaseU) ? BaseT : zi;
    if (x == BaseT) begin
      if (y == BaseT)      r = is_purine(z) ? "L" : "F";
      else if (y == BaseC) r = "S";
      else if (y == BaseA) r = is_purine(z) ? ResStop : "Y";
      else if (z == BaseA) r = ResStop;
      else                 r = (z == BaseG) ? "W" : "C";
    end else if (x == BaseC) begin
      if (y == BaseT)      r = "L";
      else if (y == BaseC) r = "P";
      else if (y == BaseA) r = is_purine(z) ? "Q" : "H";
      else                 r = "R";
    end else if (x == BaseA) begin
      if (y == BaseT)      r = (z == BaseG) ? "M" : "I";
      else if (y == BaseC) r = "T";
      else if (y == BaseA) r = is_purine(z) ? "K" : "N";
      else                 r = is_purine(z) ? "R" : "S";
    end else begin
      if (y == BaseT)      r = "V";
      else if (y == BaseC) r = "A";
      else if (y == BaseA) r = is_purine(z) ? "E" : "D";
      else                 r = "G";
    end
    return r;
  endfunction

  function automatic logic [ClassW-1:0] charge_of(input logic [CharW-1:0] r);
    logic [ClassW-1:0] k;
    case (r)
      "R", "H", "K":                 k = ClsPositive;
      "D", "E":                      k = ClsNegative;
      "A", "C", "F", "G", "I", "L",
      "M", "P", "V", "W", "Y":       k = ClsHydrophobic;
      "N", "S", "T", "Q":            k = ClsHydrophilic;
      default:                       k = ClsUnknown;
    endcase
    return k;
  endfunction

endpackage

// ----- design/stc_if.sv -----
// ----------------------------------------------------------------------------
// stc_char_if / stc_res_if
// Valid/ready channels for character beats and result beats.
// ----------------------------------------------------------------------------
interface stc_char_if;
  logic                        valid;
  logic                        ready;
  logic [stc_pkg::CharW-1:0]   character;
  logic                        seq_last;

  modport source (output valid, output character, output seq_last, input ready);
  modport sink   (input valid, input character, input seq_last, output ready);
endinterface

interface stc_res_if;
  logic                        valid;
  logic                        ready;
  logic [stc_pkg::CharW-1:0]   residue;
  logic [stc_pkg::ClassW-1:0]  charge_class;
  logic                        has_residue;
  logic                        protein_end;

  modport source (output valid, output residue, output charge_class,
                  output has_residue, output protein_end, input ready);
  modport sink   (input valid, input residue, input charge_class,
                  input has_residue, input protein_end, output ready);
endinterface

// ----- design/stc_fsm.sv -----
// ----------------------------------------------------------------------------
// stc_fsm
// Sequence state and per-character translation step.
// ----------------------------------------------------------------------------
module stc_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [stc_pkg::CharW-1:0]  character_i,
  input  logic                       seq_last_i,
  input  logic                       require_start_i,
  input  logic [1:0]                 frame_offset_i,
  output logic                       emit_o,
  output stc_pkg::res_t              res_o
);

  localparam logic [1:0] PhHead  = 2'd0;
  localparam logic [1:0] PhXlate = 2'd1;
  localparam logic [1:0] PhDone  = 2'd2;

  logic [1:0]                phase_q, phase_d;
  logic [stc_pkg::BaseW-1:0] hist0_q, hist0_d, hist1_q, hist1_d;
  logic [1:0]                cnt_q, cnt_d;
  logic [1:0]                skip_q, skip_d;
  logic [stc_pkg::BaseW-1:0] code;
  logic [stc_pkg::CharW-1:0] letter;
  logic [stc_pkg::CharW-1:0] res;
  logic                      has;
  logic                      fin;
  logic [1:0]                cnt_eff;

  always_comb begin
    code    = stc_pkg::encode_base(character_i);
    letter  = stc_pkg::codon_letter(hist1_q, hist0_q, code);
    phase_d = phase_q;
    hist0_d = hist0_q;
    hist1_d = hist1_q;
    cnt_d   = cnt_q;
    skip_d  = skip_q;
    emit_o  = 1'b0;
    has     = 1'b0;
    fin     = 1'b0;
    res     = stc_pkg::ResNone;
    cnt_eff = (phase_q == PhHead) ? 2'd0 : cnt_q;

    if (code != stc_pkg::BaseNone) begin
      if (phase_q == PhHead && require_start_i) begin
        if (hist1_q == stc_pkg::BaseA && hist0_q == stc_pkg::BaseT &&
            code == stc_pkg::BaseG) begin
          emit_o  = 1'b1;
          has     = 1'b1;
          res     = stc_pkg::ResStart;
          phase_d = PhXlate;
          cnt_d   = 2'd0;
        end else begin
          hist1_d = hist0_q;
          hist0_d = code;
        end
      end else if (phase_q == PhHead && skip_q < frame_offset_i) begin
        skip_d = skip_q + 2'd1;
      end else if (phase_q == PhHead || phase_q == PhXlate) begin
        phase_d = PhXlate;
        case (cnt_eff)
          2'd0: begin
            hist1_d = code;
            cnt_d   = 2'd1;
          end
          2'd1: begin
            hist0_d = code;
            cnt_d   = 2'd2;
          end
          default: begin
            cnt_d  = 2'd0;
            emit_o = 1'b1;
            if (letter == stc_pkg::ResStop) begin
              fin     = 1'b1;
              phase_d = PhDone;
            end else begin
              has = 1'b1;
              res = letter;
            end
          end
        endcase
      end
    end

    if (seq_last_i) begin
      if (phase_d != PhDone) begin
        emit_o = 1'b1;
        fin    = 1'b1;
      end
      phase_d = PhHead;
      hist0_d = stc_pkg::BaseNone;
      hist1_d = stc_pkg::BaseNone;
      cnt_d   = 2'd0;
      skip_d  = 2'd0;
    end

    res_o.residue      = has ? res : stc_pkg::ResNone;
    res_o.charge_class = has ? stc_pkg::charge_of(res) : stc_pkg::ClsUnknown;
    res_o.has_residue  = has;
    res_o.protein_end  = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHead;
      hist0_q <= stc_pkg::BaseNone;
      hist1_q <= stc_pkg::BaseNone;
      cnt_q   <= 2'd0;
      skip_q  <= 2'd0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      hist0_q <= hist0_d;
      hist1_q <= hist1_d;
      cnt_q   <= cnt_d;
      skip_q  <= skip_d;
    end
  end

endmodule

// ----- design/start_codon_translator.sv -----
// An accepted character beat is held in the input register; the translation
// step then writes its result beat into the result register.
// Throughput: one character beat per cycle; a held result stalls input only
// when the next character also produces a result beat.
// Reset: rst_ni clears sequence state and sets require_start=1, frame_offset=0.
// ----------------------------------------------------------------------------
// start_codon_translator
// Translates an ASCII DNA stream into amino acid residues with charge class.
// ----------------------------------------------------------------------------
module start_codon_translator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  stc_char_if.sink                     char_i,
  stc_res_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [stc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [stc_pkg::CfgW-1:0]     cfg_data_i
);

  logic                      require_start_q;
  logic [1:0]                frame_offset_q;
  logic                      in_valid_q;
  logic [stc_pkg::CharW-1:0] in_char_q;
  logic                      in_last_q;
  logic                      out_valid_q;
  stc_pkg::res_t             out_q;
  logic                      emit;
  stc_pkg::res_t             res;
  logic                      out_free;
  logic                      adv;
  logic                      take;

  assign out_free     = !out_valid_q || res_o.ready;
  assign adv          = in_valid_q && (!emit || out_free);
  assign char_i.ready = !in_valid_q || adv;
  assign take         = char_i.valid && char_i.ready;

  stc_fsm u_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .character_i     (in_char_q),
    .seq_last_i      (in_last_q),
    .require_start_i (require_start_q),
    .frame_offset_i  (frame_offset_q),
    .emit_o          (emit),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      require_start_q <= 1'b1;
      frame_offset_q  <= 2'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stc_pkg::CfgRequireStart: require_start_q <= cfg_data_i[0];
        stc_pkg::CfgFrameOffset:  frame_offset_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_char_q <= char_i.character;
      in_last_q <= char_i.seq_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_q <= res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.residue      = out_q.residue;
  assign res_o.charge_class = out_q.charge_class;
  assign res_o.has_residue  = out_q.has_residue;
  assign res_o.protein_end  = out_q.protein_end;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for start_codon_translator. A directed run covers
// start search, codon packing, stops, dropped characters and sequence ends.
// It is followed by random DNA text under several register settings. Every
// result beat is compared field by field with a typed directed value or with
// a behavioral translation model, while the character source idles in bursts and the result sink stalls.
// ----------------------------------------------------------------------------
module tb;
  import stc_pkg::*;

  typedef enum logic [1:0] {PhHead, PhXlate, PhDone} xl_phase_e;
  typedef enum logic [1:0] {ChkModel, ChkNone, ChkTyped} chk_e;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
    chk_e             chk;
    res_t             want;
  } stim_row_t;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned NumSettings = 7;
  localparam int unsigned PhaseItems  = 200;
  localparam bit [6:0]    RsPlan      = 7'b1010100;
  localparam logic [13:0] OffPlan     = {2'd0, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};

  localparam res_t NoRes    = '0;
  localparam res_t EndOnly  = {ResNone, ClsUnknown, 1'b0, 1'b1};
  localparam res_t StartRes = {ResStart, ClsHydrophobic, 1'b1, 1'b0};

  // codon letters indexed by 16*first + 4*second + third, base order T C A G
  localparam logic [8*64-1:0] AminoTable =
    "FFLLSSSSYYXXCCXWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  stc_char_if ch_if ();
  stc_res_if  rs_if ();

  start_codon_translator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_i     (ch_if),
    .res_o      (rs_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  logic             cfg_require_start;
  logic [1:0]       cfg_frame_offset;
  xl_phase_e        xl_phase;
  logic [BaseW-1:0] hist0;
  logic [BaseW-1:0] hist1;
  logic [1:0]       held;
  logic [1:0]       skipped;

  res_t        protein_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  logic [31:0] rx_cycle = '0;
  int unsigned rx_mode = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [BaseW-1:0] base_code(input logic [CharW-1:0] c);
    case (c)
      "A":     return BaseA;
      "C":     return BaseC;
      "G":     return BaseG;
      "T":     return BaseT;
      "U":     return BaseU;
      default: return BaseNone;
    endcase
  endfunction

  function automatic int unsigned codon_rank(input logic [BaseW-1:0] b);
    if (b == BaseC) return 1;
    if (b == BaseA) return 2;
    if (b == BaseG) return 3;
    return 0;
  endfunction

  function automatic logic [CharW-1:0] amino_of(input logic [BaseW-1:0] x,
                                                input logic [BaseW-1:0] y,
                                                input logic [BaseW-1:0] z);
    int unsigned idx;
    idx = 16 * codon_rank(x) + 4 * codon_rank(y) + codon_rank(z);
    return AminoTable[8*(63-idx) +: 8];
  endfunction

  function automatic logic [ClassW-1:0] class_of(input logic [CharW-1:0] r);
    case (r)
      "K", "R", "H":                          return ClsPositive;
      "E", "D":                               return ClsNegative;
      "Q", "T", "S", "N":                     return ClsHydrophilic;
      "Y", "W", "V", "P", "M", "L", "I",
      "G", "F", "C", "A":                     return ClsHydrophobic;
      default:                                return ClsUnknown;
    endcase
  endfunction

  function automatic void restart_strand();
    xl_phase = PhHead;
    hist0    = BaseNone;
    hist1    = BaseNone;
    held     = 2'd0;
    skipped  = 2'd0;
  endfunction

  function automatic bit translate_char(input logic [CharW-1:0] ch_in, input logic last_in,
                                        output res_t res);
    logic [CharW-1:0] ch;
    logic [BaseW-1:0] code;
    logic [CharW-1:0] amino;
    bit               emit;
    bit               has;
    bit               fin;
    ch    = ch_in;
    emit  = 1'b0;
    has   = 1'b0;
    fin   = 1'b0;
    amino = ResNone;
    if (ch >= "a" && ch <= "z") ch = ch - 8'd32;
    code = base_code(ch);
    if (code != BaseNone) begin
      if (xl_phase == PhHead && cfg_require_start) begin
        if (hist1 == BaseA && hist0 == BaseT && code == BaseG) begin
          emit     = 1'b1;
          has      = 1'b1;
          amino    = ResStart;
          xl_phase = PhXlate;
          held     = 2'd0;
        end else begin
          hist1 = hist0;
          hist0 = code;
        end
      end else if (xl_phase == PhHead && skipped < cfg_frame_offset) begin
        skipped = skipped + 2'd1;
      end else if (xl_phase != PhDone) begin
        if (xl_phase == PhHead) begin
          xl_phase = PhXlate;
          held     = 2'd0;
        end
        if (held == 2'd0) begin
          hist1 = code;
          held  = 2'd1;
        end else if (held == 2'd1) begin
          hist0 = code;
          held  = 2'd2;
        end else begin
          amino = amino_of(hist1, hist0, code);
          held  = 2'd0;
          emit  = 1'b1;
          if (amino == ResStop) begin
            fin      = 1'b1;
            xl_phase = PhDone;
          end else begin
            has = 1'b1;
          end
        end
      end
    end
    if (last_in) begin
      if (xl_phase != PhDone) begin
        emit = 1'b1;
        fin  = 1'b1;
      end
      restart_strand();
    end
    res = {has ? amino : ResNone, has ? class_of(amino) : ClsUnknown, has, fin};
    return emit;
  endfunction

  function automatic logic [CharW-1:0] rand_char();
    logic [CharW-1:0] c;
    case ($urandom_range(0, 9))
      0:       c = CharW'($urandom_range(0, 255));
      1, 2:    c = "A";
      3, 4:    c = "C";
      5, 6:    c = "G";
      7, 8:    c = "T";
      default: c = "U";
    endcase
    if ($urandom_range(0, 3) == 0 && c >= "A" && c <= "Z") c = c + 8'd32;
    return c;
  endfunction

  task automatic send_char(input logic [CharW-1:0] ch, input logic last, input chk_e chk,
                           input res_t want);
    res_t predicted;
    bit   emitted;
    ch_if.valid     <= 1'b1;
    ch_if.character <= ch;
    ch_if.seq_last  <= last;
    do @(posedge clk_i); while (ch_if.ready !== 1'b1);
    emitted = translate_char(ch, last, predicted);
    if (chk == ChkTyped) protein_q.push_back(want);
    else if (chk == ChkModel && emitted) protein_q.push_back(predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      ch_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(0, 20);
    end
  endtask

  task automatic drain_results();
    ch_if.valid <= 1'b0;
    do @(posedge clk_i); while (protein_q.size() != 0);
  endtask

  task automatic apply_setting(input logic rs, input logic [1:0] off);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgRequireStart;
    cfg_data_i <= {1'b0, rs};
    @(posedge clk_i);
    cfg_require_start = rs;
    cfg_idx_i  <= CfgFrameOffset;
    cfg_data_i <= off;
    @(posedge clk_i);
    cfg_frame_offset = off;
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    stim_row_t        rows [0:24];
    logic [CharW-1:0] strand_q[$];
    int unsigned      sent;
    int unsigned      len;
    int unsigned      atg_at;
    bit               want_atg;
    bit               leave_open;
    bit               paused;
    ch_if.valid     <= 1'b0;
    ch_if.character <= '0;
    ch_if.seq_last  <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CfgRequireStart;
    cfg_data_i      <= '0;
    cfg_require_start = 1'b1;
    cfg_frame_offset  = 2'd0;
    restart_strand();

    rows[0]  = '{"a",   1'b0, ChkModel, NoRes};
    rows[1]  = '{"t",   1'b0, ChkModel, NoRes};
    rows[2]  = '{"g",   1'b0, ChkTyped, StartRes};
    rows[3]  = '{"C",   1'b0, ChkModel, NoRes};
    rows[4]  = '{"G",   1'b0, ChkModel, NoRes};
    rows[5]  = '{"A",   1'b0, ChkModel, NoRes};
    rows[6]  = '{8'h00, 1'b0, ChkModel, NoRes};
    rows[7]  = '{"T",   1'b0, ChkModel, NoRes};
    rows[8]  = '{"g",   1'b0, ChkModel, NoRes};
    rows[9]  = '{8'hFF, 1'b0, ChkModel, NoRes};
    rows[10] = '{"G",   1'b1, ChkModel, NoRes};
    rows[11] = '{"A",   1'b0, ChkModel, NoRes};
    rows[12] = '{"T",   1'b0, ChkModel, NoRes};
    rows[13] = '{"G",   1'b0, ChkTyped, StartRes};
    rows[14] = '{"G",   1'b0, ChkModel, NoRes};
    rows[15] = '{"A",   1'b0, ChkModel, NoRes};
    rows[16] = '{"C",   1'b0, ChkModel, NoRes};
    rows[17] = '{"a",   1'b0, ChkModel, NoRes};
    rows[18] = '{"a",   1'b0, ChkModel, NoRes};
    rows[19] = '{"c",   1'b0, ChkModel, NoRes};
    rows[20] = '{"u",   1'b0, ChkModel, NoRes};
    rows[21] = '{"A",   1'b0, ChkModel, NoRes};
    rows[22] = '{"G",   1'b0, ChkTyped, EndOnly};
    rows[23] = '{"A",   1'b1, ChkNone,  NoRes};
    rows[24] = '{"z",   1'b1, ChkTyped, EndOnly};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 25; i++) send_char(rows[i].ch, rows[i].last, rows[i].chk, rows[i].want);

    for (int p = 0; p < NumSettings; p++) begin
      apply_setting(RsPlan[p], OffPlan[2*p +: 2]);
      sent   = 0;
      paused = 1'b0;
      while (sent < PhaseItems) begin
        len      = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
        want_atg = cfg_require_start && ($urandom_range(0, 9) < 7);
        atg_at   = $urandom_range(0, len);
        strand_q.delete();
        for (int k = 0; k <= len; k++) begin
          if (want_atg && k == atg_at) begin
            strand_q.push_back("A");
            strand_q.push_back("T");
            strand_q.push_back("G");
          end
          if (k < len) strand_q.push_back(rand_char());
        end
        // leave the last strand of a setting open across the register write
        leave_open = (sent + strand_q.size() >= PhaseItems) && ($urandom_range(0, 1) == 1);
        foreach (strand_q[k]) begin
          send_char(strand_q[k], (k == strand_q.size() - 1) && !leave_open, ChkModel, NoRes);
        end
        sent += strand_q.size();
        if (p == 3 && !paused && sent >= PhaseItems / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && protein_q.size() == 0) begin
      $display("start_codon_translator regression: pass");
    end else begin
      $display("start_codon_translator regression: fail");
    end
    $finish;
  end

  always @(posedge clk_i) begin : rx_stall
    rx_cycle <= rx_cycle + 32'd1;
    if (rx_cycle[7:0] == 8'd0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       rs_if.ready <= 1'b1;
      1:       rs_if.ready <= ($urandom_range(0, 3) != 0);
      2:       rs_if.ready <= ($urandom_range(0, 7) == 0);
      default: rs_if.ready <= (rx_cycle[3:2] != 2'b11);
    endcase
  end

  always @(posedge clk_i) begin : res_check
    res_t got;
    res_t want;
    got = {rs_if.residue, rs_if.charge_class, rs_if.has_residue, rs_if.protein_end};
    if (rst_ni && rs_if.valid === 1'b1 && rs_if.ready === 1'b1) begin
      if (protein_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: residue %h class %0d has %0b end %0b",
                   got.residue, got.charge_class, got.has_residue, got.protein_end);
      end else begin
        want = protein_q.pop_front();
        if (got.residue !== want.residue || got.charge_class !== want.charge_class ||
            got.has_residue !== want.has_residue || got.protein_end !== want.protein_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp residue %h class %0d has %0b end %0b, got %h %0d %0b %0b",
                     want.residue, want.charge_class, want.has_residue, want.protein_end,
                     got.residue, got.charge_class, got.has_residue, got.protein_end);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((ch_if.valid === 1'b1 && ch_if.ready === 1'b1) ||
        (rs_if.valid === 1'b1 && rs_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("start_codon_translator regression: fail");
      $finish;
    end
  end

endmodule
